FILE: rtl/afi_pkg.sv
// ----------------------------------------------------------------------------
// afi_pkg
// Shared types and constants of the audio sample FIFO interface: request and
// response payloads, opcodes, register indexes and FIFO command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package afi_pkg;

   localparam int FIFO_DEPTH_DEF = 512;
   localparam int SAMPLE_W       = 16;
   localparam int ADC_W          = 12;
   localparam int CODE_W         = 12;
   localparam int COUNT_W        = 10;
   localparam int GAIN_W         = 16;
   localparam int OFFSET_W       = 12;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int PROD_W         = SAMPLE_W + GAIN_W + 1;
   localparam int FRAC_W         = 12;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd4096;
   localparam logic [CODE_W-1:0]   MID_DAC8     = 12'd128;
   localparam logic [CODE_W-1:0]   MID_PWM12    = 12'd2048;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN   = 16'h8000;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_PUSH_TX     = 3'd1,
      OP_POP_RX      = 3'd2,
      OP_CLEAR_FLAGS = 3'd3,
      OP_CLEAR_FIFOS = 3'd4
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_MODE = 2'd0,
      CSR_TX_GAIN     = 2'd1,
      CSR_RX_BIAS     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]                 opcode;
      logic [ADC_W-1:0]           adc_code;
      logic signed [SAMPLE_W-1:0] tx_word;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]          dac_code;
      logic                       accepted;
      logic signed [SAMPLE_W-1:0] rx_word;
      logic                       rx_overflow;
      logic                       tx_overflow;
      logic [COUNT_W-1:0]         rx_count;
      logic [COUNT_W-1:0]         tx_count;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clr_drop;
      logic clear;
   } fifo_cmd_type;

   typedef struct packed {
      logic               push_ok;
      logic               pop_ok;
      logic               drop;
      logic [COUNT_W-1:0] count;
   } fifo_stat_type;

endpackage

`default_nettype wire

FILE: rtl/audio_sample_fifo_interface_core.sv
// ----------------------------------------------------------------------------
// audio_sample_fifo_interface_core
// Audio converter interface with a receive and a transmit sample FIFO.
//
//   channel   dir   handshake             payload
//   req_      in    req_valid/req_ready   afi_pkg::req_type
//   rsp_      out   rsp_valid/rsp_ready   afi_pkg::rsp_type
//   csr_      in    csr_we                csr_index, csr_wdata
//
// One request per cycle while rsp_ready keeps the output register free; a
// request passes the store read, the gain multiply register and the output
// register before rsp_valid rises.
// FIFO pointers and flags update at acceptance, so requests overlap freely.
// Reset clears pointers, flags and pipeline valids; store contents hold.
// A stalled response holds the output register; the stages behind it fill
// before req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_sample_fifo_interface_core #(
   parameter int FIFO_DEPTH = afi_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire afi_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output afi_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [afi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [afi_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import afi_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   // configuration
   logic                       output_mode_ff;
   logic [GAIN_W-1:0]          tx_gain_ff;
   logic signed [OFFSET_W-1:0] rx_bias_ff;

   // handshake
   logic accept;
   logic out_free, s2_ready, s1_ready;

   // FIFO control
   fifo_cmd_type       rx_cmd, tx_cmd;
   fifo_stat_type      rx_stat, tx_stat;
   logic [PTR_W-1:0]   rx_waddr, rx_raddr, tx_waddr, tx_raddr;
   logic [SAMPLE_W-1:0] rx_rd_data, tx_rd_data;
   logic [SAMPLE_W-1:0] rx_conv;
   logic                acc;

   // ADC conversion
   logic signed [ADC_W+1:0] centred;

   // stage 1: request decoded, store read in flight
   logic               s1_v_ff;
   logic               s1_tick_ff, s1_pop_ff, s1_acc_ff;
   logic               s1_rx_ovf_ff, s1_tx_ovf_ff;
   logic [COUNT_W-1:0] s1_rx_cnt_ff, s1_tx_cnt_ff;

   // stage 2: gain product registered
   logic                       s2_v_ff;
   logic                       s2_tick_ff, s2_acc_ff;
   logic                       s2_rx_ovf_ff, s2_tx_ovf_ff;
   logic [COUNT_W-1:0]         s2_rx_cnt_ff, s2_tx_cnt_ff;
   logic signed [PROD_W-1:0]   s2_prod_ff;
   logic [SAMPLE_W-1:0]        s2_rx_word_ff;
   logic signed [PROD_W-1:0]   prod_in;

   // output register
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic [CODE_W-1:0] shaped_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_mode_ff <= 1'b0;
         tx_gain_ff     <= GAIN_RESET;
         rx_bias_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OUTPUT_MODE: output_mode_ff <= csr_wdata[0];
            CSR_TX_GAIN:     tx_gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_RX_BIAS:     rx_bias_ff     <= csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_v_ff || out_free;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_ready = s1_ready && !reset;
   assign accept    = req_valid && req_ready;

   // centre, remove offset, clamp to 12 bits signed, scale by 8
   always_comb begin
      centred = $signed({2'b00, req_data.adc_code}) - 14'sd2048
              - {{2{rx_bias_ff[OFFSET_W-1]}}, rx_bias_ff};
      if (centred > 14'sd2047) begin
         rx_conv = {1'b0, 12'h7FF, 3'b000};
      end else if (centred < -14'sd2048) begin
         rx_conv = {1'b1, 12'h800, 3'b000};
      end else begin
         rx_conv = {centred[ADC_W-1], centred[ADC_W-1:0], 3'b000};
      end
   end

   always_comb begin
      rx_cmd = '0;
      tx_cmd = '0;
      if (accept) begin
         unique case (req_data.opcode)
            OP_TICK: begin
               rx_cmd.push = 1'b1;
               tx_cmd.pop  = 1'b1;
            end
            OP_PUSH_TX: begin
               tx_cmd.push = 1'b1;
            end
            OP_POP_RX: begin
               rx_cmd.pop = 1'b1;
            end
            OP_CLEAR_FLAGS: begin
               rx_cmd.clr_drop = 1'b1;
               tx_cmd.clr_drop = 1'b1;
            end
            OP_CLEAR_FIFOS: begin
               rx_cmd.clear = 1'b1;
               tx_cmd.clear = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign acc = tx_stat.pop_ok || tx_stat.push_ok || rx_stat.pop_ok;

   afi_fifo_ctl #(.DEPTH(FIFO_DEPTH), .PTR_W(PTR_W)) u_rx_ctl (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rx_cmd),
      .stat    (rx_stat),
      .wr_addr (rx_waddr),
      .rd_addr (rx_raddr)
   );

   afi_fifo_ctl #(.DEPTH(FIFO_DEPTH), .PTR_W(PTR_W)) u_tx_ctl (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tx_cmd),
      .stat    (tx_stat),
      .wr_addr (tx_waddr),
      .rd_addr (tx_raddr)
   );

   afi_sample_ram #(.DEPTH(FIFO_DEPTH), .PTR_W(PTR_W)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_stat.push_ok),
      .wr_addr (rx_waddr),
      .wr_data (rx_conv),
      .rd_en   (rx_stat.pop_ok),
      .rd_addr (rx_raddr),
      .rd_data (rx_rd_data)
   );

   afi_sample_ram #(.DEPTH(FIFO_DEPTH), .PTR_W(PTR_W)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_stat.push_ok),
      .wr_addr (tx_waddr),
      .wr_data (req_data.tx_word),
      .rd_en   (tx_stat.pop_ok),
      .rd_addr (tx_raddr),
      .rd_data (tx_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tick_ff   <= (req_data.opcode == OP_TICK);
         s1_pop_ff    <= (req_data.opcode == OP_POP_RX);
         s1_acc_ff    <= acc;
         s1_rx_ovf_ff <= rx_stat.drop;
         s1_tx_ovf_ff <= tx_stat.drop;
         s1_rx_cnt_ff <= rx_stat.count;
         s1_tx_cnt_ff <= tx_stat.count;
      end
   end

   assign prod_in = $signed(tx_rd_data) * $signed({1'b0, tx_gain_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff && s2_ready) begin
         s2_tick_ff    <= s1_tick_ff;
         s2_acc_ff     <= s1_acc_ff;
         s2_rx_ovf_ff  <= s1_rx_ovf_ff;
         s2_tx_ovf_ff  <= s1_tx_ovf_ff;
         s2_rx_cnt_ff  <= s1_rx_cnt_ff;
         s2_tx_cnt_ff  <= s1_tx_cnt_ff;
         s2_prod_ff    <= prod_in;
         s2_rx_word_ff <= (s1_pop_ff && s1_acc_ff) ? rx_rd_data : '0;
      end
   end

   afi_tx_shaper u_shaper (
      .product    (s2_prod_ff),
      .mode_pwm   (output_mode_ff),
      .got_sample (s2_acc_ff),
      .code       (shaped_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_v_ff && out_free) begin
         rsp_data_ff.dac_code    <= s2_tick_ff ? shaped_code : '0;
         rsp_data_ff.accepted    <= s2_acc_ff;
         rsp_data_ff.rx_word     <= s2_rx_word_ff;
         rsp_data_ff.rx_overflow <= s2_rx_ovf_ff;
         rsp_data_ff.tx_overflow <= s2_tx_ovf_ff;
         rsp_data_ff.rx_count    <= s2_rx_cnt_ff;
         rsp_data_ff.tx_count    <= s2_tx_cnt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_one_store_op_per_fifo: assert property (@(posedge clock) disable iff (reset)
      !(rx_stat.push_ok && rx_stat.pop_ok) && !(tx_stat.push_ok && tx_stat.pop_ok))
      else $error("fifo store written and read by one request");

   a_accept_needs_free_stage: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_v_ff || s2_ready))
      else $error("request accepted over a held stage");

   a_stage_moves_forward: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_ready) |=> s2_v_ff)
      else $error("stage 1 request lost");

endmodule

`default_nettype wire

FILE: rtl/afi_sample_ram.sv
// ----------------------------------------------------------------------------
// afi_sample_ram
// Sample store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module afi_sample_ram #(
   parameter int DEPTH = afi_pkg::FIFO_DEPTH_DEF,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [PTR_W-1:0]              wr_addr,
   input  wire logic [afi_pkg::SAMPLE_W-1:0]  wr_data,
   input  wire logic                          rd_en,
   input  wire logic [PTR_W-1:0]              rd_addr,
   output logic      [afi_pkg::SAMPLE_W-1:0]  rd_data
);
   import afi_pkg::*;

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/afi_fifo_ctl.sv
// ----------------------------------------------------------------------------
// afi_fifo_ctl
// Pointers, full flag and sticky drop flag of one circular sample FIFO.
// Produces the store addresses and the status after the current request.
// ----------------------------------------------------------------------------
`default_nettype none

module afi_fifo_ctl #(
   parameter int DEPTH = afi_pkg::FIFO_DEPTH_DEF,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire afi_pkg::fifo_cmd_type  cmd,
   output afi_pkg::fifo_stat_type      stat,
   output logic [PTR_W-1:0]            wr_addr,
   output logic [PTR_W-1:0]            rd_addr
);
   import afi_pkg::*;

   localparam int               CNT_W    = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic             full_ff, full_in;
   logic             drop_ff, drop_in;
   logic             empty;
   logic [PTR_W-1:0] wr_inc, rd_inc;
   logic [CNT_W-1:0] count;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      empty  = (wr_ff == rd_ff) && !full_ff;
      wr_inc = ptr_inc(wr_ff);
      rd_inc = ptr_inc(rd_ff);

      stat.push_ok = cmd.push && !full_ff;
      stat.pop_ok  = cmd.pop && !empty;

      wr_in   = wr_ff;
      rd_in   = rd_ff;
      full_in = full_ff;
      drop_in = drop_ff;
      if (cmd.clear) begin
         wr_in   = '0;
         rd_in   = '0;
         full_in = 1'b0;
         drop_in = 1'b0;
      end else begin
         if (stat.push_ok) begin
            wr_in   = wr_inc;
            full_in = (wr_inc == rd_ff);
         end
         if (cmd.push && full_ff) begin
            drop_in = 1'b1;
         end
         if (stat.pop_ok) begin
            rd_in   = rd_inc;
            full_in = 1'b0;
         end
         if (cmd.clr_drop) begin
            drop_in = 1'b0;
         end
      end

      // occupancy after this request, wrapping modulo the depth
      if (wr_in == rd_in) begin
         count = full_in ? CNT_W'(DEPTH) : '0;
      end else if (wr_in > rd_in) begin
         count = CNT_W'(wr_in) - CNT_W'(rd_in);
      end else begin
         count = CNT_W'(DEPTH) - CNT_W'(rd_in) + CNT_W'(wr_in);
      end

      stat.drop  = drop_in;
      stat.count = COUNT_W'(count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         full_ff <= 1'b0;
         drop_ff <= 1'b0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         full_ff <= full_in;
         drop_ff <= drop_in;
      end
   end

   assign wr_addr = wr_ff;
   assign rd_addr = rd_ff;

   a_full_ptrs_equal: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (wr_ff == rd_ff))
      else $error("fifo full with pointers apart");

   a_refused_push_drops: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && full_ff && !cmd.clear && !cmd.clr_drop) |=> drop_ff)
      else $error("refused push did not set drop flag");

   a_pop_clears_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && !empty && !cmd.push) |=> !full_ff)
      else $error("fifo still full after pop");

endmodule

`default_nettype wire

FILE: rtl/afi_tx_shaper.sv
// ----------------------------------------------------------------------------
// afi_tx_shaper
// Scales a gained transmit product back by the Q4.12 fraction (toward zero),
// saturates to 16 bits and packs it as a DAC or PWM code.
// ----------------------------------------------------------------------------
`default_nettype none

module afi_tx_shaper (
   input  wire logic signed [afi_pkg::PROD_W-1:0] product,
   input  wire logic                              mode_pwm,
   input  wire logic                              got_sample,
   output logic [afi_pkg::CODE_W-1:0]             code
);
   import afi_pkg::*;

   localparam int Q_W = PROD_W - FRAC_W;

   logic [PROD_W-1:0]   adj;
   logic [Q_W-1:0]      q;
   logic [SAMPLE_W-1:0] sat;
   logic [SAMPLE_W-1:0] biased;

   always_comb begin
      // bias negative products so the shift truncates toward zero
      adj = product + {{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{product[PROD_W-1]}}};
      q   = adj[PROD_W-1:FRAC_W];

      if (q[Q_W-1:SAMPLE_W-1] == '0 || q[Q_W-1:SAMPLE_W-1] == '1) begin
         sat = q[SAMPLE_W-1:0];
      end else begin
         sat = q[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end

      biased = {~sat[SAMPLE_W-1], sat[SAMPLE_W-2:0]};

      if (!got_sample) begin
         code = mode_pwm ? MID_PWM12 : MID_DAC8;
      end else if (mode_pwm) begin
         code = biased[SAMPLE_W-1:4];
      end else begin
         code = {4'd0, biased[SAMPLE_W-1:8]};
      end
   end

endmodule

`default_nettype wire
